/* rtl/systolic_matrix_multiply_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef SYSTOLIC_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SYSTOLIC_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smm check failed");

// Next-cycle implication, disabled during reset.
`define SMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smm check failed");

// Next-cycle implication that also holds across reset.
`define SMM_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("smm check failed");

`endif

/* rtl/smm_pkg.sv */
`default_nettype none
package smm_pkg;
    localparam int DEF_ARRAY_ROWS = 8;
    localparam int DEF_ARRAY_COLS = 8;
    localparam int DEF_INNER_MAX  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int REQ_W       = 2;
    localparam int IDX_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int OUT_IDX_W   = 3;
    localparam int SUM_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int ROWS_CFG_W  = 4;
    localparam int INNER_CFG_W = 5;
    localparam int COLS_CFG_W  = 4;

    localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = 4'd8;
    localparam logic [INNER_CFG_W-1:0] INNER_RESET = 5'd16;
    localparam logic [COLS_CFG_W-1:0]  COLS_RESET  = 4'd8;

    localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    localparam int DRAIN_CYCLES = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic feed;
        logic wr_a;
        logic wr_b;
        logic emit;
        logic emit_last;
    } t_cmd;
endpackage
`default_nettype wire

/* rtl/smm_ram.sv */
`default_nettype none
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

/* rtl/smm_cell.sv */
`default_nettype none
module smm_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_clear,
    input  wire logic [DATA_WIDTH-1:0] i_west,
    input  wire logic [DATA_WIDTH-1:0] i_north,
    output logic      [DATA_WIDTH-1:0] o_east,
    output logic      [DATA_WIDTH-1:0] o_south,
    output logic      [DATA_WIDTH-1:0] o_acc
);
    logic [DATA_WIDTH-1:0] r_east;
    logic [DATA_WIDTH-1:0] r_south;
    logic [DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_east  <= '0;
            r_south <= '0;
            r_prod  <= '0;
            r_acc   <= '0;
        end else begin
            r_east  <= i_west;
            r_south <= i_north;
            r_prod  <= i_west * i_north;
            r_acc   <= r_acc + r_prod;
        end
    end

    assign o_east  = r_east;
    assign o_south = r_south;
    assign o_acc   = r_acc;
endmodule
`default_nettype wire

/* rtl/smm_dp.sv */
`default_nettype none
module smm_dp #(
    parameter int ARRAY_ROWS = smm_pkg::DEF_ARRAY_ROWS,
    parameter int ARRAY_COLS = smm_pkg::DEF_ARRAY_COLS,
    parameter int INNER_MAX  = smm_pkg::DEF_INNER_MAX,
    parameter int DATA_WIDTH = smm_pkg::DEF_DATA_WIDTH,
    localparam int SW = $clog2(INNER_MAX + ARRAY_ROWS + ARRAY_COLS - 1),
    localparam int NW = $clog2(INNER_MAX + 1),
    localparam int RW = (ARRAY_ROWS > 1) ? $clog2(ARRAY_ROWS) : 1,
    localparam int CW = (ARRAY_COLS > 1) ? $clog2(ARRAY_COLS) : 1
) (
    input  wire logic                              i_clk,
    input  wire smm_pkg::t_cmd                     i_cmd,
    input  wire logic [SW-1:0]                     i_step,
    input  wire logic [NW-1:0]                     i_n,
    input  wire logic [RW-1:0]                     i_erow,
    input  wire logic [CW-1:0]                     i_ecol,
    input  wire logic [smm_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [smm_pkg::IDX_W-1:0]         i_col_index,
    input  wire logic signed [smm_pkg::VALUE_W-1:0] i_value,
    output logic      [smm_pkg::OUT_IDX_W-1:0]     o_out_row,
    output logic      [smm_pkg::OUT_IDX_W-1:0]     o_out_col,
    output logic signed [smm_pkg::SUM_W-1:0]       o_product_sum,
    output logic                                   o_last
);
    import smm_pkg::*;

    localparam int AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;

    logic [63:0]           w_val64;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [DATA_WIDTH-1:0] w_west  [ARRAY_ROWS];
    logic [DATA_WIDTH-1:0] w_north [ARRAY_COLS];
    logic [DATA_WIDTH-1:0] w_east  [ARRAY_ROWS][ARRAY_COLS];
    logic [DATA_WIDTH-1:0] w_south [ARRAY_ROWS][ARRAY_COLS];
    logic [DATA_WIDTH-1:0] w_acc   [ARRAY_ROWS][ARRAY_COLS];
    logic [63:0]           w_acc64;
    logic                  w_k_ok;

    assign w_val64   = {{32{i_value[31]}}, i_value};
    assign w_wr_data = w_val64[DATA_WIDTH-1:0];
    assign w_k_ok    = 32'(i_col_index) < INNER_MAX;

    for (genvar r = 0; r < ARRAY_ROWS; r++) begin : g_west
        logic [SW-1:0]         w_top;
        logic                  w_ok;
        logic                  r_valid;
        logic [DATA_WIDTH-1:0] w_rd;

        assign w_top = SW'(i_n) - SW'(1) + SW'(r);
        assign w_ok  = (i_step >= SW'(r)) && (i_step <= w_top);

        smm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(INNER_MAX)) u_a_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_cmd.wr_a && (i_row_index == IDX_W'(r)) && w_k_ok),
            .i_wr_addr (AW'(i_col_index)),
            .i_wr_data (w_wr_data),
            .i_rd_addr (AW'(w_top - i_step)),
            .o_rd_data (w_rd)
        );

        always_ff @(posedge i_clk) begin
            r_valid <= i_cmd.feed && w_ok;
        end

        assign w_west[r] = r_valid ? w_rd : '0;
    end

    for (genvar c = 0; c < ARRAY_COLS; c++) begin : g_north
        logic [SW-1:0]         w_top;
        logic                  w_ok;
        logic                  r_valid;
        logic [DATA_WIDTH-1:0] w_rd;

        assign w_top = SW'(i_n) - SW'(1) + SW'(c);
        assign w_ok  = (i_step >= SW'(c)) && (i_step <= w_top);

        smm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(INNER_MAX)) u_b_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_cmd.wr_b && (i_col_index == IDX_W'(c))
                        && (32'(i_row_index) < INNER_MAX)),
            .i_wr_addr (AW'(i_row_index)),
            .i_wr_data (w_wr_data),
            .i_rd_addr (AW'(w_top - i_step)),
            .o_rd_data (w_rd)
        );

        always_ff @(posedge i_clk) begin
            r_valid <= i_cmd.feed && w_ok;
        end

        assign w_north[c] = r_valid ? w_rd : '0;
    end

    for (genvar r = 0; r < ARRAY_ROWS; r++) begin : g_row
        for (genvar c = 0; c < ARRAY_COLS; c++) begin : g_col
            logic [DATA_WIDTH-1:0] w_w;
            logic [DATA_WIDTH-1:0] w_n;

            if (c == 0) begin : g_edge_w
                assign w_w = w_west[r];
            end else begin : g_inner_w
                assign w_w = w_east[r][c-1];
            end
            if (r == 0) begin : g_edge_n
                assign w_n = w_north[c];
            end else begin : g_inner_n
                assign w_n = w_south[r-1][c];
            end

            smm_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_clear (i_cmd.clear),
                .i_west  (w_w),
                .i_north (w_n),
                .o_east  (w_east[r][c]),
                .o_south (w_south[r][c]),
                .o_acc   (w_acc[r][c])
            );
        end
    end

    assign w_acc64 = 64'(w_acc[i_erow][i_ecol]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_row     <= OUT_IDX_W'(i_erow);
            o_out_col     <= OUT_IDX_W'(i_ecol);
            o_product_sum <= w_acc64[SUM_W-1:0];
            o_last        <= i_cmd.emit_last;
        end
    end
endmodule
`default_nettype wire

/* rtl/smm_ctrl.sv */
`default_nettype none
module smm_ctrl #(
    parameter int ARRAY_ROWS = smm_pkg::DEF_ARRAY_ROWS,
    parameter int ARRAY_COLS = smm_pkg::DEF_ARRAY_COLS,
    parameter int INNER_MAX  = smm_pkg::DEF_INNER_MAX,
    localparam int SW = $clog2(INNER_MAX + ARRAY_ROWS + ARRAY_COLS - 1),
    localparam int NW = $clog2(INNER_MAX + 1),
    localparam int RW = (ARRAY_ROWS > 1) ? $clog2(ARRAY_ROWS) : 1,
    localparam int CW = (ARRAY_COLS > 1) ? $clog2(ARRAY_COLS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [smm_pkg::REQ_W-1:0]     i_req_type,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output smm_pkg::t_cmd                      o_cmd,
    output logic      [SW-1:0]                 o_step,
    output logic      [NW-1:0]                 o_n,
    output logic      [RW-1:0]                 o_erow,
    output logic      [CW-1:0]                 o_ecol
);
    import smm_pkg::*;

    localparam int MW = $clog2(ARRAY_ROWS + 1);
    localparam int PW = $clog2(ARRAY_COLS + 1);

    t_state                 r_state, n_state;
    logic [ROWS_CFG_W-1:0]  r_cfg_rows;
    logic [INNER_CFG_W-1:0] r_cfg_inner;
    logic [COLS_CFG_W-1:0]  r_cfg_cols;
    logic [MW-1:0]          r_m, n_m;
    logic [NW-1:0]          r_n, n_n;
    logic [PW-1:0]          r_p, n_p;
    logic [SW-1:0]          r_step, n_step;
    logic [SW-1:0]          r_last_step, n_last_step;
    logic                   r_drain, n_drain;
    logic [RW-1:0]          r_erow, n_erow;
    logic [CW-1:0]          r_ecol, n_ecol;
    logic                   r_out_valid, n_out_valid;
    logic                   w_row_end;
    logic                   w_col_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_rows  <= ROWS_RESET;
            r_cfg_inner <= INNER_RESET;
            r_cfg_cols  <= COLS_RESET;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_last_step <= '0;
            r_drain     <= 1'b0;
            r_erow      <= '0;
            r_ecol      <= '0;
            r_m         <= MW'(1);
            r_n         <= NW'(1);
            r_p         <= PW'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_last_step <= n_last_step;
            r_drain     <= n_drain;
            r_erow      <= n_erow;
            r_ecol      <= n_ecol;
            r_m         <= n_m;
            r_n         <= n_n;
            r_p         <= n_p;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROWS:  r_cfg_rows  <= i_cfg_data[ROWS_CFG_W-1:0];
                    CFG_INNER: r_cfg_inner <= i_cfg_data[INNER_CFG_W-1:0];
                    CFG_COLS:  r_cfg_cols  <= i_cfg_data[COLS_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_row_end = (MW'(r_erow) == r_m - MW'(1));
    assign w_col_end = (PW'(r_ecol) == r_p - PW'(1));

    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_n         = r_n;
        n_p         = r_p;
        n_step      = r_step;
        n_last_step = r_last_step;
        n_drain     = r_drain;
        n_erow      = r_erow;
        n_ecol      = r_ecol;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_req_type)
                        REQ_WR_A: o_cmd.wr_a = 1'b1;
                        REQ_WR_B: o_cmd.wr_b = 1'b1;
                        REQ_RUN: begin
                            n_state = ST_CLEAR;
                            n_m = (r_cfg_rows == '0) ? MW'(1) :
                                  ((32'(r_cfg_rows) > ARRAY_ROWS) ? MW'(ARRAY_ROWS) :
                                   MW'(r_cfg_rows));
                            n_n = (r_cfg_inner == '0) ? NW'(1) :
                                  ((32'(r_cfg_inner) > INNER_MAX) ? NW'(INNER_MAX) :
                                   NW'(r_cfg_inner));
                            n_p = (r_cfg_cols == '0) ? PW'(1) :
                                  ((32'(r_cfg_cols) > ARRAY_COLS) ? PW'(ARRAY_COLS) :
                                   PW'(r_cfg_cols));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_step      = '0;
                n_last_step = SW'(r_n) + SW'(r_m) + SW'(r_p) - SW'(3);
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.feed = 1'b1;
                if (r_step == r_last_step) begin
                    n_state = ST_DRAIN;
                    n_drain = 1'b0;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_drain == 1'(DRAIN_CYCLES - 1)) begin
                    n_state = ST_EMIT;
                    n_erow  = '0;
                    n_ecol  = '0;
                end else begin
                    n_drain = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = w_row_end && w_col_end;
                    n_out_valid     = 1'b1;
                    if (w_col_end) begin
                        n_ecol = '0;
                        if (w_row_end) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_erow = r_erow + RW'(1);
                        end
                    end else begin
                        n_ecol = r_ecol + CW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_step      = r_step;
    assign o_n         = r_n;
    assign o_erow      = r_erow;
    assign o_ecol      = r_ecol;
endmodule
`default_nettype wire

/* rtl/systolic_matrix_multiply_top.sv */
// Output-stationary systolic multiplier of an M x N matrix A by an N x P matrix B, with
// one cell and one multiplier per element of C. Write items for A and B are taken one per
// cycle while idle, into one small RAM per array row and one per array column. A run item
// passes through a clear state, a feed state in which the skewed operands stream through
// the grid, and a drain state for the read latency and the product register to settle;
// the M*P sums then leave in row-major order, one per cycle while the consumer keeps ready
// high, the last marked by last. No input item is taken from the run until its final sum
// has been loaded into the output register.
`default_nettype none
module systolic_matrix_multiply_top #(
    parameter int ARRAY_ROWS = smm_pkg::DEF_ARRAY_ROWS,
    parameter int ARRAY_COLS = smm_pkg::DEF_ARRAY_COLS,
    parameter int INNER_MAX  = smm_pkg::DEF_INNER_MAX,
    parameter int DATA_WIDTH = smm_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [smm_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic [smm_pkg::IDX_W-1:0]          i_row_index,
    input  wire logic [smm_pkg::IDX_W-1:0]          i_col_index,
    input  wire logic signed [smm_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [smm_pkg::OUT_IDX_W-1:0]      o_out_row,
    output logic      [smm_pkg::OUT_IDX_W-1:0]      o_out_col,
    output logic signed [smm_pkg::SUM_W-1:0]        o_product_sum,
    output logic                                    o_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [smm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import smm_pkg::*;

    localparam int SW = $clog2(INNER_MAX + ARRAY_ROWS + ARRAY_COLS - 1);
    localparam int NW = $clog2(INNER_MAX + 1);
    localparam int RW = (ARRAY_ROWS > 1) ? $clog2(ARRAY_ROWS) : 1;
    localparam int CW = (ARRAY_COLS > 1) ? $clog2(ARRAY_COLS) : 1;

    t_cmd          w_cmd;
    logic [SW-1:0] w_step;
    logic [NW-1:0] w_n;
    logic [RW-1:0] w_erow;
    logic [CW-1:0] w_ecol;

    smm_ctrl #(
        .ARRAY_ROWS (ARRAY_ROWS),
        .ARRAY_COLS (ARRAY_COLS),
        .INNER_MAX  (INNER_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .o_step      (w_step),
        .o_n         (w_n),
        .o_erow      (w_erow),
        .o_ecol      (w_ecol)
    );

    smm_dp #(
        .ARRAY_ROWS (ARRAY_ROWS),
        .ARRAY_COLS (ARRAY_COLS),
        .INNER_MAX  (INNER_MAX),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_step        (w_step),
        .i_n           (w_n),
        .i_erow        (w_erow),
        .i_ecol        (w_ecol),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_value       (i_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_product_sum (o_product_sum),
        .o_last        (o_last)
    );
endmodule
`default_nettype wire

/* rtl/smm_checker.sv */
`default_nettype none
`include "systolic_matrix_multiply_top_assert.svh"
module smm_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic [smm_pkg::REQ_W-1:0]          i_req_type,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [smm_pkg::SUM_W-1:0]   o_product_sum,
    input wire logic                               o_last
);
    import smm_pkg::*;

    `SMM_ASSERT_ALWAYS(a_reset_no_output, !i_rst_n, !o_out_valid)
    `SMM_ASSERT_NEXT(a_run_goes_busy, i_in_valid && o_in_ready && (i_req_type == REQ_RUN),
        !o_in_ready)
    `SMM_ASSERT_NOW(a_busy_until_last, o_out_valid && i_out_ready && !o_last, !o_in_ready)
    `SMM_ASSERT_NEXT(a_stalled_result_holds, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_product_sum) && $stable(o_last))
endmodule

bind systolic_matrix_multiply_top smm_checker u_smm_checker (.*);
`default_nettype wire

/* tb/systolic_matrix_multiply_top_tb.sv */
`default_nettype none
module systolic_matrix_multiply_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smm_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 2'd3;
    localparam int                   N_ITEMS    = 420;
    localparam int                   CYCLE_CAP  = 2000000;
    localparam int                   SETTLE     = 24;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct {
        logic [OUT_IDX_W-1:0]    row;
        logic [OUT_IDX_W-1:0]    col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_sum;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [REQ_W-1:0]              i_req_type = '0;
    logic [IDX_W-1:0]              i_row_index = '0;
    logic [IDX_W-1:0]              i_col_index = '0;
    logic signed [VALUE_W-1:0]     i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [OUT_IDX_W-1:0]          o_out_row;
    logic [OUT_IDX_W-1:0]          o_out_col;
    logic signed [SUM_W-1:0]       o_product_sum;
    logic                          o_last;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    systolic_matrix_multiply_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    t_req        pending_reqs[$];
    t_sum        expected_sums[$];
    int          errors = 0;
    int          cycles = 0;
    bit          sender_hold = 1'b0;
    int          hold_off_requests = 0;

    // Predictor state, updated on accepted transfers.
    logic [31:0] mat_a[DEF_ARRAY_ROWS][DEF_INNER_MAX];
    logic [31:0] mat_b[DEF_INNER_MAX][DEF_ARRAY_COLS];
    logic [ROWS_CFG_W-1:0]  pr_rows  = ROWS_RESET;
    logic [INNER_CFG_W-1:0] pr_inner = INNER_RESET;
    logic [COLS_CFG_W-1:0]  pr_cols  = COLS_RESET;

    // Generator view of the registers and of which store entries hold data.
    int gen_rows = 8, gen_inner = 16, gen_cols = 8;
    bit a_loaded[DEF_ARRAY_ROWS][DEF_INNER_MAX];
    bit b_loaded[DEF_INNER_MAX][DEF_ARRAY_COLS];
    int gen_count = 0;

    function automatic int clamp_dim(int v, int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic apply_request(t_req rq);
        int m, n, p;
        logic [31:0] acc;
        t_sum s;
        case (rq.kind)
            REQ_WR_A: begin
                if (rq.row < DEF_ARRAY_ROWS) mat_a[rq.row][rq.col] = rq.value;
            end
            REQ_WR_B: begin
                if (rq.col < DEF_ARRAY_COLS) mat_b[rq.row][rq.col] = rq.value;
            end
            REQ_RUN: begin
                m = clamp_dim(pr_rows, DEF_ARRAY_ROWS);
                n = clamp_dim(pr_inner, DEF_INNER_MAX);
                p = clamp_dim(pr_cols, DEF_ARRAY_COLS);
                for (int r = 0; r < m; r++) begin
                    for (int c = 0; c < p; c++) begin
                        acc = '0;
                        for (int k = 0; k < n; k++) acc = acc + mat_a[r][k] * mat_b[k][c];
                        s.row = r[OUT_IDX_W-1:0];
                        s.col = c[OUT_IDX_W-1:0];
                        s.sum = acc;
                        s.last = (r == m - 1) && (c == p - 1);
                        expected_sums.push_back(s);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (!sender_hold && pending_reqs.size() > 0) begin
                t_req rq;
                rq = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= rq.kind;
                i_row_index <= rq.row;
                i_col_index <= rq.col;
                i_value <= rq.value;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that changes now and then, plus long hold-offs on request.
    int rx_period = 1, rx_duty = 1, rx_phase = 0, rx_hold = 0, hold_offs_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_offs_done != hold_off_requests) begin
            hold_offs_done <= hold_off_requests;
            rx_hold <= 400;
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_phase == 63) begin
                rx_period <= $urandom_range(5, 1);
                rx_duty <= $urandom_range(5, 0);
            end
            rx_phase <= (rx_phase + 1) % 64;
            i_out_ready <= (rx_phase % rx_period) < rx_duty || rx_period == 1;
        end
    end

    // Monitor: prediction on accepted requests and register writes, checking of sums.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS:  pr_rows  <= i_cfg_data[ROWS_CFG_W-1:0];
                    CFG_INNER: pr_inner <= i_cfg_data[INNER_CFG_W-1:0];
                    CFG_COLS:  pr_cols  <= i_cfg_data[COLS_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                apply_request('{i_req_type, i_row_index, i_col_index, i_value});
            if (o_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%t: unexpected sum row %0d col %0d value %0d", $realtime,
                             o_out_row, o_out_col, o_product_sum);
                    errors++;
                end else begin
                    t_sum s;
                    s = expected_sums.pop_front();
                    if (s.row !== o_out_row || s.col !== o_out_col || s.sum !== o_product_sum
                        || s.last !== o_last) begin
                        $display({"%t: expected row %0d col %0d sum %0d last %0b, ",
                                  "got %0d %0d %0d %0b"},
                                 $realtime, s.row, s.col, s.sum, s.last,
                                 o_out_row, o_out_col, o_product_sum, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_req(logic [REQ_W-1:0] kind, int row, int col, logic [31:0] value);
        pending_reqs.push_back('{kind, row[IDX_W-1:0], col[IDX_W-1:0], value});
        gen_count++;
        if (kind == REQ_WR_A && row < DEF_ARRAY_ROWS) a_loaded[row][col] = 1'b1;
        if (kind == REQ_WR_B && col < DEF_ARRAY_COLS) b_loaded[row][col] = 1'b1;
    endtask

    task automatic push_run();
        int m, n, p;
        m = clamp_dim(gen_rows, DEF_ARRAY_ROWS);
        n = clamp_dim(gen_inner, DEF_INNER_MAX);
        p = clamp_dim(gen_cols, DEF_ARRAY_COLS);
        for (int r = 0; r < m; r++)
            for (int k = 0; k < n; k++)
                if (!a_loaded[r][k]) push_req(REQ_WR_A, r, k, $urandom);
        for (int k = 0; k < n; k++)
            for (int c = 0; c < p; c++)
                if (!b_loaded[k][c]) push_req(REQ_WR_B, k, c, $urandom);
        push_req(REQ_RUN, $urandom_range(15, 0), $urandom_range(15, 0), $urandom);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid || expected_sums.size() > 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v, int width);
        logic [31:0] data;
        data = ($urandom & ~((32'd1 << width) - 1)) | v;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROWS:  gen_rows = v;
            CFG_INNER: gen_inner = v;
            CFG_COLS:  gen_cols = v;
            default: ;
        endcase
    endtask

    task automatic set_dims(int m, int n, int p);
        wait_idle();
        write_reg(CFG_ROWS, m, ROWS_CFG_W);
        write_reg(CFG_INNER, n, INNER_CFG_W);
        write_reg(CFG_COLS, p, COLS_CFG_W);
    endtask

    function automatic int small_dim(int hi);
        return ($urandom_range(5, 0) == 0) ? $urandom_range(hi, 0) : $urandom_range(3, 1);
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_dims(2, 3, 2);
        write_reg(CFG_NONE, 5, 4);
        push_req(REQ_WR_A, 0, 0, 32'h8000_0000);
        push_req(REQ_WR_A, 0, 1, 32'h7fff_ffff);
        push_req(REQ_WR_A, 0, 2, 32'hffff_ffff);
        push_req(REQ_WR_A, 1, 0, 32'h0);
        push_req(REQ_WR_B, 0, 0, 32'h8000_0000);
        push_req(REQ_WR_B, 1, 0, 32'h7fff_ffff);
        push_req(REQ_WR_B, 2, 1, 32'hffff_ffff);
        push_req(REQ_WR_A, 8, 0, $urandom);
        push_req(REQ_WR_A, 15, 15, $urandom);
        push_req(REQ_WR_B, 0, 8, $urandom);
        push_req(REQ_WR_B, 15, 15, $urandom);
        push_req(REQ_NONE, 1, 1, $urandom);
        push_run();
        set_dims(0, 0, 0);
        push_run();
        set_dims(15, 31, 15);
        push_run();

        // Fill the block while the receiver holds off, then let everything drain.
        set_dims(3, 4, 3);
        hold_off_requests++;
        push_run();
        for (int i = 0; i < 12; i++) push_req(REQ_WR_A, $urandom_range(2, 0),
                                              $urandom_range(3, 0), $urandom);
        push_run();
        sender_hold = 1'b1;
        do @(negedge i_clk);
        while (i_in_valid || expected_sums.size() > 0);
        sender_hold = 1'b0;

        while (gen_count < N_ITEMS) begin
            set_dims(small_dim(15), small_dim(31), small_dim(15));
            for (int i = 0; i < 25; i++) begin
                int pick;
                pick = $urandom_range(19, 0);
                if (pick < 12)
                    push_req(pick[0] ? REQ_WR_A : REQ_WR_B, $urandom_range(15, 0),
                             $urandom_range(15, 0), $urandom);
                else if (pick < 14)
                    push_req(REQ_NONE, $urandom_range(15, 0), $urandom_range(15, 0), $urandom);
                else if (pick < 15)
                    push_req(REQ_WR_A, $urandom_range(15, 8), $urandom_range(15, 0), $urandom);
                else
                    push_run();
            end
        end

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_cell.sv
rtl/smm_dp.sv
rtl/smm_ctrl.sv
rtl/systolic_matrix_multiply_top.sv
rtl/smm_checker.sv
tb/systolic_matrix_multiply_top_tb.sv
